### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) `ASSERT(label, !(expr), msg)
`else
`define ASSERT(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

### rtl/core/rrma_pkg.sv
// ----------------------------------------------------------------------------
// rrma_pkg
// Types and constants shared by the round-robin memory arbiter.
// ----------------------------------------------------------------------------
package rrma_pkg;

  localparam int unsigned ARB_CLIENTS = 4;
  localparam int unsigned CLIENT_W    = 2;
  localparam int unsigned ARB_LINES   = 1024;
  localparam int unsigned LINE_AW     = $clog2(ARB_LINES);
  localparam int unsigned LINE_BITS   = 256;
  localparam int unsigned LINE_BYTES  = LINE_BITS / 8;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned BASE_W      = 5;

  localparam logic [BASE_W-1:0] DELAY_BASE_RST = BASE_W'(2);

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_READTHRU  = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_WRITETHRU = 3'd3;

  typedef struct packed {
    logic [3:0]  request_valid;
    logic [2:0]  operation;
    logic [9:0]  line_address;
    logic [63:0] write_data_lo;
    logic [63:0] write_data_ml;
    logic [63:0] write_data_mh;
    logic [63:0] write_data_hi;
    logic [31:0] byte_enable;
    logic [3:0]  extra_delay;
  } arb_in_t;

  typedef struct packed {
    logic [3:0]  stall_mask;
    logic [3:0]  read_valid_mask;
    logic [1:0]  served_client;
    logic [63:0] read_data_lo;
    logic [63:0] read_data_ml;
    logic [63:0] read_data_mh;
    logic [63:0] read_data_hi;
  } arb_out_t;

  typedef struct packed {
    logic                accept;
    logic                rd;
    logic                wr;
    logic                clr_stall;
    logic [CLIENT_W-1:0] cur_client;
    logic [CLIENT_W-1:0] new_client;
    logic                load_out;
  } arb_cmd_t;

endpackage

### rtl/core/round_robin_memory_arbiter.sv
// ----------------------------------------------------------------------------
// round_robin_memory_arbiter
// Round-robin arbiter for up to four clients in front of a 32-byte line store.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------
//  in       | in_valid_i/in_ready_o | in_data_i   (arb_in_t)
//  out      | out_valid_o/out_ready_i | out_data_o (arb_out_t)
//  cfg      | cfg_we_i              | cfg_wdata_i (delay base)
//
// One transaction per clock is taken while in_ready_o is high. Each result is
// registered in the line store read and accept stage, then in the result
// register. A stalled result holds the input side after one buffered item.
// Reset clears control, flags and the read line; the line store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_memory_arbiter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rrma_pkg::arb_in_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rrma_pkg::arb_out_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [rrma_pkg::BASE_W-1:0] cfg_wdata_i
);

  import rrma_pkg::*;

  arb_cmd_t cmd;

  rrma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_o      (cmd)
  );

  rrma_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .out_data_o(out_data_o)
  );

endmodule

### rtl/core/rrma_ram.sv
// ----------------------------------------------------------------------------
// rrma_ram
// Single-port RAM with byte write enables and registered read.
// ----------------------------------------------------------------------------
module rrma_ram #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [WIDTH/8-1:0]       be_i,
  output logic [WIDTH-1:0]         rdata_o
);

  localparam int unsigned BE_W = WIDTH / 8;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < BE_W; b++) begin
        if (be_i[b]) begin
          mem_q[addr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/rrma_ctrl.sv
// ----------------------------------------------------------------------------
// rrma_ctrl
// Arbiter state machine: round-robin grant, access countdown, handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrma_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rrma_pkg::arb_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          cfg_we_i,
  input  logic [rrma_pkg::BASE_W-1:0]   cfg_wdata_i,
  output rrma_pkg::arb_cmd_t            cmd_o
);

  import rrma_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CLIENT_W-1:0] gnt_q, gnt_d;
  logic [BASE_W-1:0]   delay_base_q;
  logic                a_valid_q, a_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                accept, load_out, rd, wr, clr;
  logic                found;
  logic [CLIENT_W-1:0] pick;
  logic [CNT_W-1:0]    load_sum;

  assign load_out    = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !a_valid_q || load_out;
  assign accept      = in_valid_i && in_ready_o;
  assign a_valid_d   = accept ? 1'b1 : (load_out ? 1'b0 : a_valid_q);
  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_comb begin
    logic [CLIENT_W-1:0] cand;
    found = 1'b0;
    pick  = gnt_q;
    for (int i = 0; i < ARB_CLIENTS; i++) begin
      cand = gnt_q + CLIENT_W'(i);
      if (!found && in_data_i.request_valid[cand]) begin
        found = 1'b1;
        pick  = cand;
      end
    end
  end

  assign load_sum = {1'b0, delay_base_q} + {2'b00, in_data_i.extra_delay};

  always_comb begin
    logic [CNT_W-1:0] cnt_dec;
    cnt_dec = cnt_q - CNT_W'(1);
    state_d = state_q;
    cnt_d   = cnt_q;
    gnt_d   = gnt_q;
    rd      = 1'b0;
    wr      = 1'b0;
    clr     = 1'b0;
    if (accept) begin
      unique case (state_q)
        ST_BUSY: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            state_d = ST_IDLE;
            rd = (in_data_i.operation == OP_READ) || (in_data_i.operation == OP_READTHRU);
            wr = (in_data_i.operation == OP_WRITE) || (in_data_i.operation == OP_WRITETHRU);
          end else if (cnt_dec == CNT_W'(1)) begin
            clr = 1'b1;
          end
        end
        ST_IDLE: begin
          if (found) begin
            gnt_d   = pick;
            cnt_d   = (load_sum == '0) ? CNT_W'(1) : load_sum;
            state_d = ST_BUSY;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      gnt_q        <= '0;
      delay_base_q <= DELAY_BASE_RST;
      a_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gnt_q       <= gnt_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        delay_base_q <= cfg_wdata_i;
      end
    end
  end

  assign cmd_o.accept     = accept;
  assign cmd_o.rd         = rd;
  assign cmd_o.wr         = wr;
  assign cmd_o.clr_stall  = clr;
  assign cmd_o.cur_client = gnt_q;
  assign cmd_o.new_client = gnt_d;
  assign cmd_o.load_out   = load_out;

  `ASSERT(busy_cnt_nz, (state_q == ST_BUSY) |-> (cnt_q != '0), "busy with zero countdown")
  `ASSERT_NEVER(rd_wr_both, rd && wr, "read and write completion together")
  `ASSERT(cmpl_at_end, (rd || wr) |-> (state_q == ST_BUSY && cnt_q == CNT_W'(1)), "early completion")
  `ASSERT(grant_busy, (accept && state_q == ST_IDLE && found) |=> (state_q == ST_BUSY), "grant lost")

endmodule

### rtl/core/rrma_datapath.sv
// ----------------------------------------------------------------------------
// rrma_datapath
// Line store, sticky read flags, stall mask and result registers.
// ----------------------------------------------------------------------------
module rrma_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrma_pkg::arb_in_t  in_data_i,
  input  rrma_pkg::arb_cmd_t cmd_i,
  output rrma_pkg::arb_out_t out_data_o
);

  import rrma_pkg::*;

  logic [3:0]          flags_q, flags_d;
  logic [3:0]          a_stall_q;
  logic [3:0]          a_flags_q;
  logic [CLIENT_W-1:0] a_client_q;
  logic                a_rd_q;
  arb_out_t            out_q;
  logic [3:0]          cur_onehot;
  logic [LINE_BITS-1:0] rdata;
  logic [LINE_BITS-1:0] wdata;

  assign cur_onehot = 4'(1) << cmd_i.cur_client;
  assign flags_d    = (flags_q & ~in_data_i.request_valid) | (cmd_i.rd ? cur_onehot : 4'b0000);
  assign wdata      = {in_data_i.write_data_hi, in_data_i.write_data_mh,
                       in_data_i.write_data_ml, in_data_i.write_data_lo};

  rrma_ram #(
    .WIDTH(LINE_BITS),
    .DEPTH(ARB_LINES)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && cmd_i.wr),
    .re_i   (cmd_i.accept && cmd_i.rd),
    .addr_i (in_data_i.line_address[LINE_AW-1:0]),
    .wdata_i(wdata),
    .be_i   (in_data_i.byte_enable),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      a_stall_q  <= '0;
      a_flags_q  <= '0;
      a_client_q <= '0;
      a_rd_q     <= 1'b0;
      out_q      <= '0;
    end else begin
      if (cmd_i.accept) begin
        flags_q    <= flags_d;
        a_flags_q  <= flags_d;
        a_stall_q  <= in_data_i.request_valid & ~(cmd_i.clr_stall ? cur_onehot : 4'b0000);
        a_client_q <= cmd_i.new_client;
        a_rd_q     <= cmd_i.rd;
      end
      if (cmd_i.load_out) begin
        out_q.stall_mask      <= a_stall_q;
        out_q.read_valid_mask <= a_flags_q;
        out_q.served_client   <= a_client_q;
        if (a_rd_q) begin
          out_q.read_data_lo <= rdata[63:0];
          out_q.read_data_ml <= rdata[127:64];
          out_q.read_data_mh <= rdata[191:128];
          out_q.read_data_hi <= rdata[255:192];
        end
      end
    end
  end

  assign out_data_o = out_q;

endmodule

### tb/round_robin_memory_arbiter_checker.sv
// ----------------------------------------------------------------------------
// round_robin_memory_arbiter_checker
// Watches the input, output and delay-base ports of the arbiter. Every
// accepted input transaction runs through a cycle model of the grant logic,
// the countdown and the line store, and the predicted result is queued. Every
// accepted output transaction is compared field by field with the oldest
// queued prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_memory_arbiter_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  rrma_pkg::arb_in_t           in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  rrma_pkg::arb_out_t          out_data_i,
  input  logic                        cfg_we_i,
  input  logic [rrma_pkg::BASE_W-1:0] cfg_wdata_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_o
);

  import rrma_pkg::*;

  logic [BASE_W-1:0]    base_q = DELAY_BASE_RST;
  bit                   busy_q = 1'b0;
  logic [CLIENT_W-1:0]  grant_q = '0;
  logic [CNT_W-1:0]     count_q = '0;
  logic [3:0]           flags_q = '0;
  logic [LINE_BITS-1:0] line_q = '0;
  logic [LINE_BITS-1:0] mem_q [ARB_LINES];
  arb_out_t             expected_q [$];
  int unsigned          mismatches = 0;
  int unsigned          pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic arb_out_t arbitrate(arb_in_t t);
    logic [3:0]           stall;
    logic [CLIENT_W-1:0]  cand;
    logic [CNT_W-1:0]     load;
    logic [LINE_BITS-1:0] wline;
    bit                   found;
    arb_out_t             r;
    stall   = t.request_valid;
    flags_q = flags_q & ~t.request_valid;
    found   = 1'b0;
    if (busy_q) begin
      count_q = count_q - CNT_W'(1);
      if (count_q == '0) begin
        if (t.operation == OP_READ || t.operation == OP_READTHRU) begin
          line_q = mem_q[t.line_address];
          flags_q[grant_q] = 1'b1;
        end else if (t.operation == OP_WRITE || t.operation == OP_WRITETHRU) begin
          wline = {t.write_data_hi, t.write_data_mh, t.write_data_ml, t.write_data_lo};
          for (int b = 0; b < LINE_BYTES; b++) begin
            if (t.byte_enable[b]) mem_q[t.line_address][8*b +: 8] = wline[8*b +: 8];
          end
        end
        busy_q = 1'b0;
      end else if (count_q == CNT_W'(1)) begin
        stall[grant_q] = 1'b0;
      end
    end else begin
      for (int i = 0; i < ARB_CLIENTS; i++) begin
        cand = grant_q + CLIENT_W'(i);
        if (!found && t.request_valid[cand]) begin
          load    = CNT_W'(base_q) + CNT_W'(t.extra_delay);
          grant_q = cand;
          count_q = (load == '0) ? CNT_W'(1) : load;
          busy_q  = 1'b1;
          found   = 1'b1;
        end
      end
    end
    r.stall_mask      = stall;
    r.read_valid_mask = flags_q;
    r.served_client   = grant_q;
    r.read_data_lo    = line_q[63:0];
    r.read_data_ml    = line_q[127:64];
    r.read_data_mh    = line_q[191:128];
    r.read_data_hi    = line_q[255:192];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
    end
  endtask

  task automatic compare_result(input arb_out_t got, input arb_out_t want);
    check_field("stall_mask", 64'(got.stall_mask), 64'(want.stall_mask));
    check_field("read_valid_mask", 64'(got.read_valid_mask), 64'(want.read_valid_mask));
    check_field("served_client", 64'(got.served_client), 64'(want.served_client));
    check_field("read_data_lo", got.read_data_lo, want.read_data_lo);
    check_field("read_data_ml", got.read_data_ml, want.read_data_ml);
    check_field("read_data_mh", got.read_data_mh, want.read_data_mh);
    check_field("read_data_hi", got.read_data_hi, want.read_data_hi);
  endtask

  initial begin
    for (int i = 0; i < ARB_LINES; i++) mem_q[i] = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) base_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) expected_q = {expected_q, arbitrate(in_data_i)};
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected (served_client %0d)",
                                    out_data_i.served_client));
        end else begin
          compare_result(out_data_i, expected_q.pop_front());
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

### tb/round_robin_memory_arbiter_tb.sv
// ----------------------------------------------------------------------------
// round_robin_memory_arbiter_tb
// Drives the arbiter with clients that hold requests until served, plus some
// noise ticks, over several delay-base settings, with random gaps and stalls
// on both channels and one long output stall. Reads only target lines whose
// bytes have all been written. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_memory_arbiter_tb;
  import rrma_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1425;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic [2:0] OP_CLEAR    = 3'd4;
  localparam logic [2:0] OP_PREFETCH = 3'd5;
  localparam logic [2:0] OP_OTHER_A  = 3'd6;
  localparam logic [2:0] OP_OTHER_B  = 3'd7;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  arb_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  arb_out_t          out_data_o;
  logic              cfg_we_i;
  logic [BASE_W-1:0] cfg_wdata_i;
  int unsigned       mismatches;
  int unsigned       results_pending;

  // access timing as the sender sees it, and which bytes of each line are known
  bit                  busy = 1'b0;
  logic [CLIENT_W-1:0] owner = '0;
  logic [CNT_W-1:0]    remaining = '0;
  logic [BASE_W-1:0]   base_delay = DELAY_BASE_RST;
  bit [31:0]           byte_known [ARB_LINES];
  logic [LINE_AW-1:0]  full_lines [$];
  logic [3:0]          want_mask = '0;
  arb_in_t             client_req [ARB_CLIENTS];
  bit                  sender_quiet = 1'b0;
  bit                  receiver_quiet = 1'b0;

  round_robin_memory_arbiter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  round_robin_memory_arbiter_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .pending_o        (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(input bit quiet);
    if (quiet) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic arb_in_t new_request();
    arb_in_t     r;
    int unsigned pick;
    r.request_valid = '0;
    pick = $urandom_range(0, 19);
    if (pick < 9)       r.operation = pick[0] ? OP_READTHRU : OP_READ;
    else if (pick < 17) r.operation = pick[0] ? OP_WRITETHRU : OP_WRITE;
    else                r.operation = 3'($urandom_range(OP_CLEAR, OP_OTHER_B));
    r.line_address  = ($urandom_range(0, 7) == 0) ? LINE_AW'($urandom)
                                                   : LINE_AW'($urandom_range(0, 31));
    r.write_data_lo = {$urandom, $urandom};
    r.write_data_ml = {$urandom, $urandom};
    r.write_data_mh = {$urandom, $urandom};
    r.write_data_hi = {$urandom, $urandom};
    pick = $urandom_range(0, 5);
    r.byte_enable   = (pick < 2) ? '1 : (pick == 2) ? '0 : 32'($urandom);
    r.extra_delay   = 4'($urandom);
    if ((r.operation == OP_READ || r.operation == OP_READTHRU) &&
        byte_known[r.line_address] != '1) begin
      if (full_lines.size() != 0) begin
        r.line_address = full_lines[$urandom_range(0, full_lines.size() - 1)];
      end else begin
        r.operation   = OP_WRITE;
        r.byte_enable = '1;
      end
    end
    return r;
  endfunction

  // advance the access timing by one tick; track written bytes and drop or renew served requests
  function automatic void track_access(input arb_in_t t);
    logic [CLIENT_W-1:0] cand;
    logic [CNT_W-1:0]    load;
    bit                  found;
    found = 1'b0;
    if (busy) begin
      remaining = remaining - CNT_W'(1);
      if (remaining == '0) begin
        busy = 1'b0;
        if (t.operation == OP_WRITE || t.operation == OP_WRITETHRU) begin
          if (byte_known[t.line_address] != '1 &&
              (byte_known[t.line_address] | t.byte_enable) == '1) begin
            full_lines = {full_lines, t.line_address};
          end
          byte_known[t.line_address] |= t.byte_enable;
        end
        if ($urandom_range(0, 3) != 0) want_mask[owner] = 1'b0;
        else client_req[owner] = new_request();
      end
    end else begin
      for (int i = 0; i < ARB_CLIENTS; i++) begin
        cand = owner + CLIENT_W'(i);
        if (!found && t.request_valid[cand]) begin
          load      = CNT_W'(base_delay) + CNT_W'(t.extra_delay);
          owner     = cand;
          remaining = (load == '0) ? CNT_W'(1) : load;
          busy      = 1'b1;
          found     = 1'b1;
        end
      end
    end
  endfunction

  function automatic arb_in_t next_tick();
    arb_in_t item;
    for (int c = 0; c < ARB_CLIENTS; c++) begin
      if (!want_mask[c] && $urandom_range(0, 3) == 0) begin
        want_mask[c]  = 1'b1;
        client_req[c] = new_request();
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      item = new_request();
      item.request_valid = 4'($urandom);
    end else begin
      item = want_mask[owner] ? client_req[owner] : new_request();
      item.request_valid = want_mask;
      item.extra_delay   = 4'($urandom);
    end
    return item;
  endfunction

  task automatic send_item(input arb_in_t item);
    int unsigned gap;
    gap = draw_gap(sender_quiet);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    track_access(item);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic directed_access(input logic [3:0] mask, input logic [2:0] op,
                                 input logic [LINE_AW-1:0] addr, input logic [63:0] fill,
                                 input logic [31:0] be, input logic [3:0] extra);
    arb_in_t item;
    item = '{request_valid: mask, operation: op, line_address: addr,
             write_data_lo: fill, write_data_ml: fill, write_data_mh: fill,
             write_data_hi: fill, byte_enable: be, extra_delay: extra};
    send_item(item);
    while (busy) send_item(item);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_delay(input logic [BASE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    base_delay  = value;
  endtask

  // output side: random stalls, one long hold-off so the input backs up
  initial begin
    int unsigned taken;
    int unsigned gap;
    taken       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(receiver_quiet);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [BASE_W-1:0] next_base;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = DELAY_BASE_RST;
    for (int i = 0; i < ARB_LINES; i++) byte_known[i] = '0;
    for (int c = 0; c < ARB_CLIENTS; c++) client_req[c] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle tick with extreme fields, then at least one access per operation
    send_item('{request_valid: 4'h0, operation: OP_OTHER_B, line_address: '1,
                write_data_lo: '1, write_data_ml: '1, write_data_mh: '1,
                write_data_hi: '1, byte_enable: '1, extra_delay: 4'hf});
    directed_access(4'b1000, OP_WRITE,     '1, '1, '1, 4'h0);
    directed_access(4'b0001, OP_WRITETHRU, '0, '0, '1, 4'h0);
    directed_access(4'b1111, OP_READ,      '1, '0, '0, 4'h0);
    directed_access(4'b0010, OP_WRITE,     '0, '1, 32'ha5a5_a5a5, 4'h1);
    directed_access(4'b0100, OP_READTHRU,  '0, '0, '0, 4'h0);
    directed_access(4'b1111, OP_CLEAR,     '0, '1, '1, 4'h0);
    directed_access(4'b1010, OP_PREFETCH,  '1, '0, '1, 4'h0);
    directed_access(4'b0101, OP_OTHER_A,   '0, '1, '1, 4'h0);
    directed_access(4'b1111, OP_OTHER_B,   '1, '1, '1, 4'h0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        if (ph == 1)      next_base = BASE_W'(1);
        else if (ph == 2) next_base = '1;
        else if (ph == 5) next_base = DELAY_BASE_RST;
        else              next_base = BASE_W'($urandom_range(1, 31));
        set_delay(next_base);
      end
      sender_quiet   = (ph == 2);
      receiver_quiet = (ph == 2 || ph == 4);
      repeat (RANDOM_ITEMS / PHASES) send_item(next_tick());
    end

    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
